@@ hdl/mrtc_pkg.sv @@
// Shared types, constants and filter helpers for the motor run timer controller.
package mrtc_pkg;

   localparam int FILTER_SHIFT   = 10;
   localparam int SAMPLE_W       = 8;
   localparam int SUM_W          = FILTER_SHIFT + SAMPLE_W;
   localparam int TIMER_W        = 18;
   localparam int RUN_TIME_SHIFT = 9;
   localparam int CFG_W          = 16;
   localparam int LEVEL_W        = 16;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [CFG_W-1:0] HOLDOFF_TICKS_RESET  = CFG_W'(500);
   localparam logic [CFG_W-1:0] RAMP_STEP_RESET      = CFG_W'(32);
   localparam logic [CFG_W-1:0] BASE_RUN_TICKS_RESET = CFG_W'(15000);

   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOFF_TICKS  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STEP      = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_RUN_TICKS = CSR_INDEX_W'(2);

   typedef enum logic [2:0] {
      MODE_READY_HOLD = 3'd0,
      MODE_READY      = 3'd1,
      MODE_RUN_HOLD   = 3'd2,
      MODE_RUN        = 3'd3,
      MODE_RAMP       = 3'd4
   } mode_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] throttle_sample;
      logic [SAMPLE_W-1:0] time_sample;
      logic                button;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] duty;
      logic [2:0]          mode;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] holdoff_ticks;
      logic [CFG_W-1:0] ramp_step;
      logic [CFG_W-1:0] base_run_ticks;
   } cfg_type;

   typedef struct packed {
      mode_type            mode;
      logic                just_entered;
      logic [CFG_W-1:0]    holdoff_count;
      logic [TIMER_W-1:0]  run_timer;
      logic [LEVEL_W-1:0]  ramp_level;
      logic [SUM_W-1:0]    throttle_sum;
      logic [SUM_W-1:0]    dur_sum;
      logic [SAMPLE_W-1:0] duty;
   } state_type;

   // Leaky-sum update: sum + sample - sum/2^FILTER_SHIFT, wrapping at SUM_W bits.
   function automatic logic [SUM_W-1:0] filter_feed(input logic [SUM_W-1:0] sum,
                                                    input logic [SAMPLE_W-1:0] sample);
      return sum + SUM_W'(sample) - (sum >> FILTER_SHIFT);
   endfunction

   function automatic logic [SAMPLE_W-1:0] filter_value(input logic [SUM_W-1:0] sum);
      return sum[SUM_W-1 -: SAMPLE_W];
   endfunction

endpackage

@@ hdl/mrtc_step.sv @@
// One tick of the controller: next mode, next datapath state and the result item.
module mrtc_step (
   input  mrtc_pkg::state_type state,
   input  mrtc_pkg::req_type   item,
   input  mrtc_pkg::cfg_type   cfg,
   output mrtc_pkg::state_type state_next,
   output mrtc_pkg::rsp_type   rsp
);
   import mrtc_pkg::*;

   logic [CFG_W-1:0]    hold_cnt;
   logic                hold_busy;
   logic                timer_live;
   logic                ramp_above;
   logic [SAMPLE_W-1:0] thr_filt;
   logic [SAMPLE_W-1:0] tim_filt;
   logic [LEVEL_W-1:0]  ramp_dec;
   mode_type            mode_next;

   // A wait state reloads its holdoff count on the first tick after entry.
   assign hold_cnt   = state.just_entered ? cfg.holdoff_ticks : state.holdoff_count;
   assign hold_busy  = (hold_cnt != '0);
   assign timer_live = (state.run_timer != '0);
   assign ramp_above = (state.ramp_level > cfg.ramp_step);
   assign ramp_dec   = state.ramp_level - cfg.ramp_step;
   assign thr_filt   = filter_value(state.throttle_sum);
   assign tim_filt   = filter_value(state.dur_sum);

   always_comb begin
      unique case (state.mode)
         MODE_READY_HOLD: mode_next = hold_busy ? MODE_READY_HOLD : MODE_READY;
         MODE_READY:      mode_next = item.button ? MODE_RUN_HOLD : MODE_READY;
         MODE_RUN_HOLD: begin
            if (!hold_busy) begin
               mode_next = MODE_RUN;
            end else if (timer_live) begin
               mode_next = MODE_RUN_HOLD;
            end else begin
               mode_next = MODE_RAMP;
            end
         end
         MODE_RUN: begin
            mode_next = (!timer_live || item.button) ? MODE_READY_HOLD : MODE_RUN;
         end
         MODE_RAMP: begin
            mode_next = (item.button || !ramp_above) ? MODE_READY_HOLD : MODE_RAMP;
         end
         default: mode_next = MODE_READY_HOLD;
      endcase
   end

   always_comb begin
      state_next              = state;
      state_next.mode         = mode_next;
      state_next.just_entered = (mode_next != state.mode);
      case (state.mode)
         MODE_READY_HOLD: begin
            state_next.holdoff_count = hold_busy ? hold_cnt - CFG_W'(1) : hold_cnt;
            if (hold_busy) begin
               state_next.throttle_sum = filter_feed(state.throttle_sum,
                                                     item.throttle_sample);
               state_next.dur_sum      = filter_feed(state.dur_sum, item.time_sample);
            end
         end
         MODE_READY: begin
            if (item.button) begin
               state_next.run_timer  = TIMER_W'(cfg.base_run_ticks)
                                     + (TIMER_W'(tim_filt) << RUN_TIME_SHIFT);
               state_next.duty       = thr_filt;
               state_next.ramp_level = {thr_filt, 8'h00};
            end else begin
               state_next.throttle_sum = filter_feed(state.throttle_sum,
                                                     item.throttle_sample);
               state_next.dur_sum      = filter_feed(state.dur_sum, item.time_sample);
            end
         end
         MODE_RUN_HOLD: begin
            state_next.holdoff_count = hold_busy ? hold_cnt - CFG_W'(1) : hold_cnt;
            if (hold_busy && timer_live) begin
               state_next.run_timer = state.run_timer - TIMER_W'(1);
            end
         end
         MODE_RUN: begin
            if (timer_live) begin
               state_next.run_timer = state.run_timer - TIMER_W'(1);
            end
            if (mode_next == MODE_READY_HOLD) begin
               state_next.duty       = '0;
               state_next.ramp_level = '0;
            end
         end
         MODE_RAMP: begin
            if (mode_next == MODE_READY_HOLD) begin
               state_next.duty       = '0;
               state_next.ramp_level = '0;
            end else begin
               state_next.ramp_level = ramp_dec;
               state_next.duty       = ramp_dec[LEVEL_W-1 -: SAMPLE_W];
            end
         end
         default: begin
            state_next.duty       = '0;
            state_next.ramp_level = '0;
         end
      endcase
   end

   assign rsp.duty = state_next.duty;
   assign rsp.mode = state_next.mode;

endmodule

@@ hdl/motor_run_timer_controller.sv @@
// Top level of the motor run timer controller: handshakes, registers and checks.
// A transferred input waits in the input register and moves into the result register,
// with the state update, once that register is empty or is being emptied.
// Throughput: one item per clock cycle while the consumer keeps rsp_ready high.
// Reset (synchronous, active high) returns the mode to ready holdoff with all counters,
// filter sums and duty at zero, holdoff to 500 ticks, ramp step to 32, base to 15000 ticks.
module motor_run_timer_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  mrtc_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mrtc_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [mrtc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mrtc_pkg::CFG_W-1:0]            csr_wdata
);
   import mrtc_pkg::*;

   // Input register: holds one accepted tick until it can be processed.
   logic      in_valid_ff;
   req_type   in_data_ff;
   // Result register: holds one finished result until the consumer takes it.
   logic      out_valid_ff;
   rsp_type   out_data_ff;
   // Controller state and configuration.
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_in;
   cfg_type   cfg_ff;
   logic      advance;

   // A tick is processed when the result register is empty or is being emptied
   // in this cycle. Processing and the state update happen in the same edge,
   // so the state seen by the next tick is always up to date.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   // The input register frees up whenever its tick moves on, so a new transfer
   // can land in every cycle while the output side keeps pace.
   assign req_ready = !in_valid_ff || advance;

   mrtc_step u_step (
      .state      (state_ff),
      .item       (in_data_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_READY_HOLD, default: '0};
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   // Configuration writes take effect at the edge of the write; indexes past
   // the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.holdoff_ticks  <= HOLDOFF_TICKS_RESET;
         cfg_ff.ramp_step      <= RAMP_STEP_RESET;
         cfg_ff.base_run_ticks <= BASE_RUN_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HOLDOFF_TICKS:  cfg_ff.holdoff_ticks  <= csr_wdata;
            CSR_RAMP_STEP:      cfg_ff.ramp_step      <= csr_wdata;
            CSR_BASE_RUN_TICKS: cfg_ff.base_run_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // The motor is off in both ready states, entered only by a stop, reset or ready holdoff.
   a_ready_duty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.mode == MODE_READY_HOLD || rsp_data.mode == MODE_READY)
      |-> rsp_data.duty == '0)
      else $error("duty is nonzero in a ready mode");

   // A waiting tick with a free result register must produce a result next cycle.
   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("tick not processed while result register was free");

   // The entry flag tracks exactly whether the last processed tick changed mode.
   a_entry_flag: assert property (@(posedge clock) disable iff (reset)
      advance |=> state_ff.just_entered == (state_ff.mode != $past(state_ff.mode)))
      else $error("entry flag does not match mode change");

   // The run state is entered only after the holdoff count has drained.
   a_run_count_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == MODE_RUN |-> state_ff.holdoff_count == '0)
      else $error("holdoff count nonzero in run mode");

endmodule
